[hdl/u16u8_pkg.sv]
// package with types, constants and the byte encoder for the utf-16 to utf-8 unit
`timescale 1ns / 1ps
`default_nettype none
package u16u8_pkg;

   localparam int UnitWidth  = 16;
   localparam int ByteWidth  = 8;
   localparam int CpWidth    = 21;
   localparam int MaxBytes   = 4;
   localparam int IdxWidth   = $clog2(MaxBytes);
   localparam int QueueDepth = 2;
   localparam int QPtrWidth  = $clog2(QueueDepth);
   localparam int QCntWidth  = $clog2(QueueDepth + 1);

   localparam logic [5:0]  SURR_HIGH_TAG  = 6'b110110;
   localparam logic [5:0]  SURR_LOW_TAG   = 6'b110111;
   localparam logic [CpWidth-1:0] SUPP_BASE = 21'h10000;
   localparam logic [1:0]  CONT_TAG       = 2'b10;
   localparam logic [2:0]  LEAD2_TAG      = 3'b110;
   localparam logic [3:0]  LEAD3_TAG      = 4'b1110;
   localparam logic [4:0]  LEAD4_TAG      = 5'b11110;

   localparam logic [IdxWidth-1:0] LAST_IDX1 = 2'd0;
   localparam logic [IdxWidth-1:0] LAST_IDX2 = 2'd1;
   localparam logic [IdxWidth-1:0] LAST_IDX3 = 2'd2;
   localparam logic [IdxWidth-1:0] LAST_IDX4 = 2'd3;

   typedef struct packed {
      logic [MaxBytes-1:0][ByteWidth-1:0] bytes;
      logic [IdxWidth-1:0]                last_idx;
   } cmd_type;

   function automatic cmd_type encode_cp(input logic [CpWidth-1:0] cp);
      cmd_type c;
      c = '0;
      if (cp[CpWidth-1:7] == '0) begin
         c.bytes[0] = {1'b0, cp[6:0]};
         c.last_idx = LAST_IDX1;
      end else if (cp[CpWidth-1:11] == '0) begin
         c.bytes[0] = {LEAD2_TAG, cp[10:6]};
         c.bytes[1] = {CONT_TAG, cp[5:0]};
         c.last_idx = LAST_IDX2;
      end else if (cp[CpWidth-1:16] == '0) begin
         c.bytes[0] = {LEAD3_TAG, cp[15:12]};
         c.bytes[1] = {CONT_TAG, cp[11:6]};
         c.bytes[2] = {CONT_TAG, cp[5:0]};
         c.last_idx = LAST_IDX3;
      end else begin
         c.bytes[0] = {LEAD4_TAG, cp[20:18]};
         c.bytes[1] = {CONT_TAG, cp[17:12]};
         c.bytes[2] = {CONT_TAG, cp[11:6]};
         c.bytes[3] = {CONT_TAG, cp[5:0]};
         c.last_idx = LAST_IDX4;
      end
      return c;
   endfunction

endpackage
`default_nettype wire

[hdl/u16u8_front.sv]
// front end: accepts code units, pairs surrogates, builds byte commands
`timescale 1ns / 1ps
`default_nettype none
module u16u8_front import u16u8_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [UnitWidth-1:0] req_code_unit,
   output logic                      push,
   output cmd_type                   push_cmd,
   input  wire logic                 push_ready
);

   logic       pending_ff, pending_in;
   logic [9:0] high_bits_ff, high_bits_in;
   logic [5:0] tag;
   logic       accept;
   logic       emit;
   logic [CpWidth-1:0] cp;

   assign tag       = req_code_unit[15:10];
   assign req_ready = push_ready;
   assign accept    = req_valid && req_ready;
   assign emit      = pending_ff || (tag != SURR_HIGH_TAG && tag != SURR_LOW_TAG);
   assign push      = accept && emit;

   always_comb begin
      if (pending_ff) begin
         cp = {1'b0, high_bits_ff, req_code_unit[9:0]} + SUPP_BASE;
      end else begin
         cp = {{(CpWidth-UnitWidth){1'b0}}, req_code_unit};
      end
   end

   assign push_cmd = encode_cp(cp);

   always_comb begin
      pending_in   = pending_ff;
      high_bits_in = high_bits_ff;
      if (accept) begin
         if (pending_ff) begin
            pending_in   = 1'b0;
            high_bits_in = '0;
         end else if (tag == SURR_HIGH_TAG) begin
            pending_in   = 1'b1;
            high_bits_in = req_code_unit[9:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= 1'b0;
         high_bits_ff <= '0;
      end else begin
         pending_ff   <= pending_in;
         high_bits_ff <= high_bits_in;
      end
   end

endmodule
`default_nettype wire

[hdl/u16u8_queue.sv]
// short command queue between front and back ends
`timescale 1ns / 1ps
`default_nettype none
module u16u8_queue import u16u8_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  cmd_type      push_cmd,
   output logic         push_ready,
   output logic         head_valid,
   output cmd_type      head_cmd,
   input  wire logic    pop
);

   cmd_type                entry_ff [QueueDepth];
   logic [QPtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCntWidth-1:0]   count_ff, count_in;

   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign push_ready = (count_ff != QCntWidth'(QueueDepth)) || pop;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

[hdl/u16u8_back.sv]
// back end: sends command bytes one per cycle unless stalled, via output register
`timescale 1ns / 1ps
`default_nettype none
module u16u8_back import u16u8_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 head_valid,
   input  cmd_type                   head_cmd,
   output logic                      pop,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [ByteWidth-1:0]      rsp_out_byte,
   output logic                      rsp_last_byte
);

   logic [IdxWidth-1:0]  idx_ff, idx_in;
   logic                 valid_ff, valid_in;
   logic [ByteWidth-1:0] byte_ff, byte_in;
   logic                 last_ff, last_in;
   logic                 load;
   logic                 at_last;

   assign load    = head_valid && (!valid_ff || rsp_ready);
   assign at_last = (idx_ff == head_cmd.last_idx);
   assign pop     = load && at_last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = 1'b1;
         byte_in  = head_cmd.bytes[idx_ff];
         last_in  = at_last;
         idx_in   = at_last ? '0 : idx_ff + 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_out_byte  = byte_ff;
   assign rsp_last_byte = last_ff;

endmodule
`default_nettype wire

[hdl/utf16_to_utf8_encoder_unit.sv]
// top level of the utf-16 to utf-8 encoder
//
// request channel (req_valid, req_ready, req_code_unit): one 16-bit utf-16
// code unit per request. a high surrogate is held and produces nothing; the
// next unit is its partner and yields a four-byte sequence. a lone low
// surrogate is dropped. other units give one to three bytes.
// response channel (rsp_valid, rsp_ready, rsp_out_byte, rsp_last_byte): one
// utf-8 byte per response, lead byte first, rsp_last_byte high on the last
// byte of each sequence.
// the first byte of a request passes through the command queue and the byte
// output register to rsp_valid. throughput: one byte per cycle while the
// receiver is ready; a request gives one to four bytes (four for a surrogate
// pair), and high surrogates or dropped units use only the request port.
// a two-entry command queue sits between the front end and the byte output
// stage; when the receiver stalls, the queue fills and req_ready drops.
// reset (synchronous, active high) empties the queue and clears any pending
// high surrogate.
`timescale 1ns / 1ps
`default_nettype none
module utf16_to_utf8_encoder_unit import u16u8_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [UnitWidth-1:0] req_code_unit,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [ByteWidth-1:0]      rsp_out_byte,
   output logic                      rsp_last_byte
);

   logic    push;
   cmd_type push_cmd;
   logic    push_ready;
   logic    head_valid;
   cmd_type head_cmd;
   logic    pop;

   u16u8_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_code_unit (req_code_unit),
      .push          (push),
      .push_cmd      (push_cmd),
      .push_ready    (push_ready)
   );

   u16u8_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop)
   );

   u16u8_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head_cmd      (head_cmd),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last_byte (rsp_last_byte)
   );

endmodule
`default_nettype wire

[hdl/u16u8_checker.sv]
// port-level checker for the utf-16 to utf-8 encoder, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module u16u8_checker import u16u8_pkg::*; (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_ready,
   input wire logic [UnitWidth-1:0] req_code_unit,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire logic [ByteWidth-1:0] rsp_out_byte,
   input wire logic                 rsp_last_byte
);

   // waiting request holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_code_unit))
      else $error("waiting request changed");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_last_byte))
      else $error("stalled response changed");

   // ascii byte always closes its sequence
   a_ascii_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_byte[7] |-> rsp_last_byte)
      else $error("ascii byte without last flag");

   // lead byte of a multi-byte sequence never closes it
   a_lead_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_byte[7:6] == 2'b11 |-> !rsp_last_byte)
      else $error("lead byte flagged last");

   // the byte after a non-final byte is a continuation byte
   a_cont_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_byte ##1 rsp_valid
         |-> rsp_out_byte[7:6] == CONT_TAG)
      else $error("missing continuation byte");

endmodule

bind utf16_to_utf8_encoder_unit u16u8_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_code_unit (req_code_unit),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_out_byte  (rsp_out_byte),
   .rsp_last_byte (rsp_last_byte)
);
`default_nettype wire

[dv/utf8_byte_checker.sv]
// checker that predicts the utf-8 bytes of each accepted code unit and compares responses
`timescale 1ns / 1ps
module utf8_byte_checker import u16u8_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic [UnitWidth-1:0] req_code_unit,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic [ByteWidth-1:0] rsp_out_byte,
   input  logic                 rsp_last_byte,
   output int                   fail_count,
   output int                   pending_count
);

   typedef struct packed {
      logic [ByteWidth-1:0] data;
      logic                 last;
   } utf8_byte_type;

   utf8_byte_type expected_bytes[$];
   logic          surrogate_held;
   logic [9:0]    held_bits;
   int            mismatch_count;

   task automatic push_byte(input logic [ByteWidth-1:0] data, input logic last);
      expected_bytes.push_back({data, last});
   endtask

   task automatic push_code_point(input logic [CpWidth-1:0] cp);
      if (cp < 21'h80) begin
         push_byte({1'b0, cp[6:0]}, 1'b1);
      end else if (cp < 21'h800) begin
         push_byte({LEAD2_TAG, cp[10:6]}, 1'b0);
         push_byte({CONT_TAG, cp[5:0]}, 1'b1);
      end else if (cp < SUPP_BASE) begin
         push_byte({LEAD3_TAG, cp[15:12]}, 1'b0);
         push_byte({CONT_TAG, cp[11:6]}, 1'b0);
         push_byte({CONT_TAG, cp[5:0]}, 1'b1);
      end else begin
         push_byte({LEAD4_TAG, cp[20:18]}, 1'b0);
         push_byte({CONT_TAG, cp[17:12]}, 1'b0);
         push_byte({CONT_TAG, cp[11:6]}, 1'b0);
         push_byte({CONT_TAG, cp[5:0]}, 1'b1);
      end
   endtask

   task automatic predict_code_unit(input logic [UnitWidth-1:0] unit);
      logic [CpWidth-1:0] cp;
      if (surrogate_held) begin
         // any unit after a high surrogate is its partner
         cp = {1'b0, held_bits, unit[9:0]} + SUPP_BASE;
         surrogate_held = 1'b0;
         held_bits = '0;
         push_code_point(cp);
      end else if (unit[15:10] == SURR_HIGH_TAG) begin
         surrogate_held = 1'b1;
         held_bits = unit[9:0];
      end else if (unit[15:10] != SURR_LOW_TAG) begin
         push_code_point({5'b0, unit});
      end
   endtask

   always @(posedge clock) begin
      utf8_byte_type want;
      if (reset) begin
         expected_bytes.delete();
         surrogate_held = 1'b0;
         held_bits = '0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_bytes.size() == 0) begin
               $error("unexpected response: out_byte %02h last_byte %0b",
                      rsp_out_byte, rsp_last_byte);
               mismatch_count++;
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_out_byte !== want.data) begin
                  $error("out_byte mismatch: expected %02h, got %02h",
                         want.data, rsp_out_byte);
                  mismatch_count++;
               end
               if (rsp_last_byte !== want.last) begin
                  $error("last_byte mismatch: expected %0b, got %0b",
                         want.last, rsp_last_byte);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            predict_code_unit(req_code_unit);
         end
      end
      pending_count = expected_bytes.size();
   end

   initial mismatch_count = 0;

   assign fail_count = mismatch_count;

endmodule

[dv/testbench.sv]
// testbench top: stimulus, idling and verdict for the utf-16 to utf-8 encoder
`timescale 1ns / 1ps
module testbench;
   import u16u8_pkg::*;

   localparam int CycleLimit = 50000;
   localparam int RandomUnits = 60;
   localparam int QuietUnits = 15;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [UnitWidth-1:0] req_code_unit = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [ByteWidth-1:0] rsp_out_byte;
   logic                 rsp_last_byte;
   int                   fail_count;
   int                   pending_count;
   int                   cycle_count = 0;
   bit                   idle_on = 1'b1;

   utf16_to_utf8_encoder_unit i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_code_unit (req_code_unit),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last_byte (rsp_last_byte)
   );

   utf8_byte_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_code_unit (req_code_unit),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last_byte (rsp_last_byte),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("== FAIL ==");
      $finish;
   end

   // receiver stalls in short bursts
   initial begin
      forever begin
         @(posedge clock);
         if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_code_unit(input logic [UnitWidth-1:0] unit);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_code_unit <= unit;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic logic [UnitWidth-1:0] pick_bmp_unit();
      case ($urandom_range(0, 4))
         0:       return 16'($urandom_range(16'h0000, 16'h007f));
         1:       return 16'($urandom_range(16'h0080, 16'h07ff));
         2:       return 16'($urandom_range(16'h0800, 16'hd7ff));
         3:       return 16'($urandom_range(16'he000, 16'hffff));
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_random_group();
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            // well-formed surrogate pair
            send_code_unit({SURR_HIGH_TAG, 10'($urandom)});
            send_code_unit({SURR_LOW_TAG, 10'($urandom)});
         end
         3: begin
            // high surrogate with an arbitrary partner
            send_code_unit({SURR_HIGH_TAG, 10'($urandom)});
            send_code_unit(16'($urandom));
         end
         4: send_code_unit({SURR_LOW_TAG, 10'($urandom)});
         default: send_code_unit(pick_bmp_unit());
      endcase
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_code_unit(16'h0000);
      send_code_unit(16'h007f);
      send_code_unit(16'h0080);
      send_code_unit(16'h07ff);
      send_code_unit(16'h0800);
      send_code_unit(16'hd7ff);
      send_code_unit(16'he000);
      send_code_unit(16'hffff);
      send_code_unit(16'hdc00);
      send_code_unit(16'hdfff);
      send_code_unit(16'hd800);
      send_code_unit(16'hdc00);
      send_code_unit(16'hdbff);
      send_code_unit(16'hdfff);
      send_code_unit(16'hd800);
      send_code_unit(16'h0041);
      send_code_unit(16'hdbff);
      send_code_unit(16'hd800);
      send_code_unit(16'hdaaa);
      send_code_unit(16'h0000);
      send_code_unit(16'hd955);
      send_code_unit(16'hffff);

      for (int i = 0; i < RandomUnits; i++) begin
         if (i == RandomUnits - QuietUnits) idle_on = 1'b0;
         send_random_group();
      end
      // high surrogate left pending at the end of the stream
      send_code_unit(16'hdbff);
      req_valid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
